// ===== rtl/gla_pkg.sv =====
// shared types, constants and helpers for the gas level alarm block
package gla_pkg;

  localparam int COUNTER_WIDTH = 8;
  localparam int MAX_DECIMALS  = 4;

  localparam int RAW_W    = 16;
  localparam int DEC_IN_W = 8;
  localparam int DEC_W    = 3;
  localparam int GAS_W    = 8;
  localparam int RANGE_W  = 16;
  localparam int THR_W    = 16;
  localparam int SCALE_W  = 14;
  localparam int PROD_W   = THR_W + SCALE_W;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  localparam logic REG_ALARM_THRESHOLD = 1'b0;

  localparam logic [GAS_W-1:0] METHANE_CODE = GAS_W'(1);
  localparam logic [COUNTER_WIDTH-1:0] FAULT_LIMIT = COUNTER_WIDTH'(20);
  localparam logic [COUNTER_WIDTH-1:0] ALARM_LIMIT = COUNTER_WIDTH'(5);
  localparam logic [COUNTER_WIDTH-1:0] COUNTER_MAX = '1;
  localparam logic [DEC_W-1:0] DEC_MAX = DEC_W'(MAX_DECIMALS);

  typedef enum logic [2:0] {
    ST_WAIT   = 3'd0,
    ST_FAULT  = 3'd1,
    ST_NORMAL = 3'd2,
    ST_PRE    = 3'd3,
    ST_COUNT  = 3'd4,
    ST_ALARM  = 3'd5,
    ST_SEND   = 3'd6,
    ST_REPORT = 3'd7
  } state_t;

  typedef struct packed {
    logic [THR_W-1:0] threshold;
    logic [THR_W-1:0] pre_limit;
  } cfg_t;

  typedef struct packed {
    logic [DEC_W-1:0] decimals;
    logic             below_pre;
    logic             below_thr;
    logic             above_thr;
  } cmp_t;

  typedef struct packed {
    logic [RAW_W-1:0]   raw;
    logic               fault;
    logic               methane;
    logic [RANGE_W-1:0] fs_range;
    cmp_t               cmp;
  } item_t;

  typedef struct packed {
    logic [2:0]         machine_state;
    logic               channel_methane;
    logic               show_value;
    logic [RAW_W-1:0]   value_raw;
    logic [DEC_W-1:0]   value_decimals;
    logic               show_start;
    logic [RANGE_W-1:0] range_out;
    logic               alarm_stop;
    logic               report_error;
  } res_t;

  function automatic logic [SCALE_W-1:0] pow10(input logic [DEC_W-1:0] d);
    logic [SCALE_W-1:0] s;
    case (d)
      3'd0:    s = SCALE_W'(1);
      3'd1:    s = SCALE_W'(10);
      3'd2:    s = SCALE_W'(100);
      3'd3:    s = SCALE_W'(1000);
      default: s = SCALE_W'(10000);
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/gla_ifs.sv =====
// valid/ready channel interfaces for sensor items and alarm results
interface gla_in_if;
  import gla_pkg::*;
  logic                valid;
  logic                ready;
  logic [RAW_W-1:0]    conc_raw;
  logic [DEC_IN_W-1:0] decimal_places;
  logic                sensor_fault;
  logic [GAS_W-1:0]    gas_kind;
  logic [RANGE_W-1:0]  sensor_full_range;

  modport source (output valid, conc_raw, decimal_places, sensor_fault,
                  gas_kind, sensor_full_range, input ready);
  modport sink   (input valid, conc_raw, decimal_places, sensor_fault,
                  gas_kind, sensor_full_range, output ready);
endinterface

interface gla_out_if;
  import gla_pkg::*;
  logic               valid;
  logic               ready;
  logic [2:0]         machine_state;
  logic               channel_methane;
  logic               show_value;
  logic [RAW_W-1:0]   value_raw;
  logic [DEC_W-1:0]   value_decimals;
  logic               show_start;
  logic [RANGE_W-1:0] range_out;
  logic               alarm_stop;
  logic               report_error;

  modport source (output valid, machine_state, channel_methane, show_value, value_raw,
                  value_decimals, show_start, range_out, alarm_stop, report_error,
                  input ready);
  modport sink   (input valid, machine_state, channel_methane, show_value, value_raw,
                  value_decimals, show_start, range_out, alarm_stop, report_error,
                  output ready);
endinterface

// ===== rtl/gla_cfg.sv =====
// configuration register file: alarm threshold and derived pre-alarm limit
module gla_cfg
  import gla_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  // floor(thr * 70 / 100) = floor(thr * 7 / 10) by reciprocal multiply
  localparam int MUL_W = 20;
  localparam int THR7_W = THR_W + 3;
  localparam int PP_W = THR7_W + MUL_W;
  localparam int PRE_SHIFT = 23;
  localparam logic [MUL_W-1:0] RECIP_10 = MUL_W'(838861);

  logic [THR_W-1:0]  threshold_r, threshold_nxt;
  logic [THR_W-1:0]  pre_r, pre_nxt;
  logic [THR7_W-1:0] thr7;
  logic [PP_W-1:0]   pre_prod;
  logic              wr_en;
  logic              sel_thr;

  assign sel_thr = (paddr[CFG_ADDR_W-1:2] == REG_ALARM_THRESHOLD);
  assign wr_en   = psel & penable & pwrite & sel_thr;
  assign pready  = 1'b1;

  assign thr7     = {pwdata[THR_W-1:0], 3'b000} - {3'b000, pwdata[THR_W-1:0]};
  assign pre_prod = PP_W'(thr7) * PP_W'(RECIP_10);

  always_comb begin
    threshold_nxt = threshold_r;
    pre_nxt       = pre_r;
    if (wr_en) begin
      threshold_nxt = pwdata[THR_W-1:0];
      pre_nxt       = pre_prod[PRE_SHIFT +: THR_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= '0;
      pre_r       <= '0;
    end else begin
      threshold_r <= threshold_nxt;
      pre_r       <= pre_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_thr) begin
      prdata = CFG_DATA_W'(threshold_r);
    end
  end

  assign cfg.threshold = threshold_r;
  assign cfg.pre_limit = pre_r;

endmodule

// ===== rtl/gla_cmp.sv =====
// decimal clamp and scaled limit comparisons for one reading
module gla_cmp
  import gla_pkg::*;
(
  input  logic [RAW_W-1:0]    raw,
  input  logic [DEC_IN_W-1:0] decimal_places,
  input  cfg_t                cfg,
  output cmp_t                cmp
);

  logic [DEC_W-1:0]   dec;
  logic [SCALE_W-1:0] scale;
  logic [PROD_W-1:0]  pre_scaled;
  logic [PROD_W-1:0]  thr_scaled;
  logic [PROD_W-1:0]  raw_ext;

  assign dec = (decimal_places > DEC_IN_W'(MAX_DECIMALS)) ? DEC_MAX : decimal_places[DEC_W-1:0];
  assign scale = pow10(dec);

  assign pre_scaled = PROD_W'(cfg.pre_limit) * PROD_W'(scale);
  assign thr_scaled = PROD_W'(cfg.threshold) * PROD_W'(scale);
  assign raw_ext    = PROD_W'(raw);

  assign cmp.decimals  = dec;
  assign cmp.below_pre = raw_ext < pre_scaled;
  assign cmp.below_thr = raw_ext < thr_scaled;
  assign cmp.above_thr = raw_ext > thr_scaled;

endmodule

// ===== rtl/gla_fsm.sv =====
// alarm state machine with fault and alarm counters and start flag
module gla_fsm
  import gla_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  step,
  input  item_t item,
  output res_t  res
);

  state_t                   state_r, state_nxt;
  logic [COUNTER_WIDTH-1:0] fault_cnt_r, fault_cnt_nxt;
  logic [COUNTER_WIDTH-1:0] alarm_cnt_r, alarm_cnt_nxt;
  logic                     started_r, started_nxt;

  // next state and counters
  always_comb begin
    state_nxt     = ST_WAIT;
    fault_cnt_nxt = fault_cnt_r;
    alarm_cnt_nxt = alarm_cnt_r;
    started_nxt   = started_r;
    unique case (state_r)
      ST_WAIT: begin
        if (item.fault) begin
          state_nxt = ST_FAULT;
        end else if (item.cmp.below_pre) begin
          state_nxt = ST_NORMAL;
        end else if (item.cmp.below_thr) begin
          state_nxt = ST_PRE;
        end else begin
          state_nxt = ST_COUNT;
        end
      end
      ST_FAULT: begin
        state_nxt = (fault_cnt_r > FAULT_LIMIT) ? ST_REPORT : ST_WAIT;
        if (fault_cnt_r != COUNTER_MAX) begin
          fault_cnt_nxt = fault_cnt_r + 1'b1;
        end
      end
      ST_NORMAL, ST_PRE, ST_ALARM: begin
        state_nxt = ST_SEND;
      end
      ST_COUNT: begin
        state_nxt = (alarm_cnt_r > ALARM_LIMIT) ? ST_ALARM : ST_SEND;
        if (alarm_cnt_r != COUNTER_MAX) begin
          alarm_cnt_nxt = alarm_cnt_r + 1'b1;
        end
      end
      ST_SEND: begin
        state_nxt   = ST_WAIT;
        started_nxt = 1'b1;
      end
      ST_REPORT: begin
        state_nxt = ST_WAIT;
      end
      default: begin
        state_nxt = ST_WAIT;
      end
    endcase
  end

  // result fields
  always_comb begin
    res                 = '0;
    res.machine_state   = state_nxt;
    res.channel_methane = item.methane;
    unique case (state_r)
      ST_SEND: begin
        res.show_value     = 1'b1;
        res.value_raw      = item.raw;
        res.value_decimals = item.cmp.decimals;
        res.alarm_stop     = item.cmp.above_thr;
        if (!started_r) begin
          res.show_start = 1'b1;
          res.range_out  = item.fs_range;
        end
      end
      ST_REPORT: begin
        res.report_error = 1'b1;
      end
      default: begin
        res.show_value = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_WAIT;
      fault_cnt_r <= '0;
      alarm_cnt_r <= '0;
      started_r   <= 1'b0;
    end else if (step) begin
      state_r     <= state_nxt;
      fault_cnt_r <= fault_cnt_nxt;
      alarm_cnt_r <= alarm_cnt_nxt;
      started_r   <= started_nxt;
    end
  end

  a_started_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    started_r |=> started_r)
    else $error("start flag cleared");

  a_start_once: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res.show_start) |=> started_r)
    else $error("start report without setting flag");

  a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> ($stable(state_r) && $stable(fault_cnt_r) && $stable(alarm_cnt_r)))
    else $error("state moved without a step");

  a_send_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEND) |-> (res.show_value && state_nxt == ST_WAIT))
    else $error("send step without value display");

endmodule

// ===== rtl/gas_level_alarm_fsm.sv =====
// Gas level alarm block: sensor items in, one state/display result out per item.
// The in_ch channel takes one sensor reading per item (raw concentration,
// decimal count, fault flag, gas kind, full range); out_ch delivers exactly one
// result item per reading: the new alarm state and the display commands.
// The threshold register is written over the APB-style port when paddr[2] is 0;
// the pre-alarm limit (70 percent) is derived from it as it is written.
// An input register holds the item with its limit comparisons, then the state
// machine step goes into the output register that drives out_ch.valid.
// With out_ch.ready high, throughput is one item per cycle; the state machine
// advances as an item moves from the input register into the output register.
// When out_ch.ready is low the result holds and one more item can wait in the
// input register; in_ch.ready drops only when both are full and stalled.
// Reset (synchronous, rst_n low) empties both registers, returns the machine
// to wait, clears both counters and the start flag, and sets the threshold to 0.
module gas_level_alarm_fsm
  import gla_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  gla_in_if.sink                in_ch,
  gla_out_if.source             out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t  cfg;
  cmp_t  in_cmp;
  item_t s1_r, s1_nxt;
  logic  s1_valid_r, s1_valid_nxt;
  res_t  step_res;
  res_t  out_r, out_nxt;
  logic  out_valid_r, out_valid_nxt;
  logic  advance;
  logic  in_take;

  gla_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gla_cmp u_cmp (
    .raw            (in_ch.conc_raw),
    .decimal_places (in_ch.decimal_places),
    .cfg            (cfg),
    .cmp            (in_cmp)
  );

  gla_fsm u_fsm (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .item  (s1_r),
    .res   (step_res)
  );

  assign advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_nxt       = s1_r;
    if (in_take) begin
      s1_valid_nxt    = 1'b1;
      s1_nxt.raw      = in_ch.conc_raw;
      s1_nxt.fault    = in_ch.sensor_fault;
      s1_nxt.methane  = (in_ch.gas_kind == METHANE_CODE);
      s1_nxt.fs_range = in_ch.sensor_full_range;
      s1_nxt.cmp      = in_cmp;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
      out_nxt       = step_res;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_r  <= s1_nxt;
    out_r <= out_nxt;
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.machine_state   = out_r.machine_state;
  assign out_ch.channel_methane = out_r.channel_methane;
  assign out_ch.show_value      = out_r.show_value;
  assign out_ch.value_raw       = out_r.value_raw;
  assign out_ch.value_decimals  = out_r.value_decimals;
  assign out_ch.show_start      = out_r.show_start;
  assign out_ch.range_out       = out_r.range_out;
  assign out_ch.alarm_stop      = out_r.alarm_stop;
  assign out_ch.report_error    = out_r.report_error;

  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !advance) |=> (s1_valid_r && $stable(s1_r)))
    else $error("stalled item lost from input register");

  a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("stepped item missing from output register");

  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> (out_valid_r && $stable(out_r)))
    else $error("stalled result changed before it was taken");

endmodule
